FILE: sv/uds_pkg.sv
package uds_pkg;

  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 24;
  localparam int ELEN_W     = 25;
  localparam int MODE_W     = 16;
  localparam int COFF_W     = 7;

  // command slots of one request, in emission order
  localparam int NUM_SLOTS  = 3;
  localparam int SLOT_FOOT  = 0;
  localparam int SLOT_MID   = 1;
  localparam int SLOT_HEAD  = 2;

  // apb register file: one 64-bit register at byte address 8*i
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_BYTE_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - CFG_BYTE_W;
  localparam logic [CFG_IDX_W-1:0] REG_SCRATCH = CFG_IDX_W'(0);

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] destination_address;
    logic [LEN_W-1:0]  byte_count;
    logic [MODE_W-1:0] transfer_mode;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] engine_source;
    logic [ADDR_W-1:0] engine_destination;
    logic [ELEN_W-1:0] engine_length;
    logic              via_scratch;
    logic [ADDR_W-1:0] copy_destination;
    logic [COFF_W-1:0] copy_offset;
    logic [LEN_W-1:0]  copy_length;
    logic [MODE_W-1:0] mode_out;
    logic              last_command;
  } cmd_t;

endpackage

FILE: sv/uds_if.sv
interface uds_req_if;
  import uds_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] source_address;
  logic [ADDR_W-1:0] destination_address;
  logic [LEN_W-1:0]  byte_count;
  logic [MODE_W-1:0] transfer_mode;

  modport source (output valid, source_address, destination_address, byte_count,
                  transfer_mode, input ready);
  modport sink (input valid, source_address, destination_address, byte_count,
                transfer_mode, output ready);
endinterface

interface uds_cmd_if;
  import uds_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] engine_source;
  logic [ADDR_W-1:0] engine_destination;
  logic [ELEN_W-1:0] engine_length;
  logic              via_scratch;
  logic [ADDR_W-1:0] copy_destination;
  logic [COFF_W-1:0] copy_offset;
  logic [LEN_W-1:0]  copy_length;
  logic [MODE_W-1:0] mode_out;
  logic              last_command;

  modport source (output valid, engine_source, engine_destination, engine_length,
                  via_scratch, copy_destination, copy_offset, copy_length, mode_out,
                  last_command, input ready);
  modport sink (input valid, engine_source, engine_destination, engine_length,
                via_scratch, copy_destination, copy_offset, copy_length, mode_out,
                last_command, output ready);
endinterface

FILE: sv/uds_plan.sv
module uds_plan #(
  parameter int LINE_BYTES = 128
) (
  input  uds_pkg::req_t                             req,
  input  logic [uds_pkg::ADDR_W-1:0]                scratch_addr,
  output uds_pkg::cmd_t [uds_pkg::NUM_SLOTS-1:0]    cmds,
  output logic [uds_pkg::NUM_SLOTS-1:0]             cmd_vld
);
  import uds_pkg::*;

  localparam int LW = $clog2(LINE_BYTES);
  localparam logic [LEN_W-1:0]  LINE_LEN  = LEN_W'(LINE_BYTES);
  localparam logic [ELEN_W-1:0] LINE_ELEN = ELEN_W'(LINE_BYTES);
  localparam logic [ELEN_W-1:0] LINE_MASK = ELEN_W'(LINE_BYTES - 1);

  logic [LW-1:0]     soff;
  logic [LW-1:0]     doff;
  logic [ADDR_W-1:0] src_line;
  logic [LEN_W-1:0]  room;
  logic [LEN_W-1:0]  head_len;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  foot_len;
  logic [LEN_W-1:0]  mid_len;
  logic [LEN_W-1:0]  head_fin;
  logic [LEN_W-1:0]  at;
  logic [ELEN_W-1:0] head_eng;
  logic [ELEN_W-1:0] span_sum;
  logic [ELEN_W-1:0] span;
  logic              has_off;
  logic              same_off;
  logic              nz;
  logic              merge;

  assign soff     = req.source_address[LW-1:0];
  assign doff     = req.destination_address[LW-1:0];
  assign src_line = {req.source_address[ADDR_W-1:LW], LW'(0)};
  assign has_off  = (soff != '0);
  assign same_off = (soff == doff);
  assign nz       = (req.byte_count != '0);

  // head covers the partial first line
  assign room     = LINE_LEN - LEN_W'(soff);
  assign head_len = !has_off ? '0 :
                    (req.byte_count > room) ? room : req.byte_count;
  assign rem      = req.byte_count - head_len;
  assign foot_len = LEN_W'(rem[LW-1:0]);
  // no whole middle line: foot folds into the head command
  assign merge    = (rem != '0) && (rem[LEN_W-1:LW] == '0);
  assign mid_len  = merge ? '0 : (rem - foot_len);
  assign head_fin = merge ? req.byte_count : head_len;
  assign head_eng = (has_off ? LINE_ELEN : '0) + (merge ? LINE_ELEN : '0);
  assign at       = head_len + mid_len;

  // mismatched offsets: whole range rounded out to lines
  assign span_sum = ELEN_W'(req.byte_count) + ELEN_W'(soff) + LINE_MASK;
  assign span     = span_sum & ~LINE_MASK;

  always_comb begin
    cmds = '0;

    cmds[SLOT_FOOT].engine_source      = req.source_address + ADDR_W'(at);
    cmds[SLOT_FOOT].engine_destination = scratch_addr;
    cmds[SLOT_FOOT].engine_length      = LINE_ELEN;
    cmds[SLOT_FOOT].via_scratch        = 1'b1;
    cmds[SLOT_FOOT].copy_destination   = req.destination_address + ADDR_W'(at);
    cmds[SLOT_FOOT].copy_offset        = '0;
    cmds[SLOT_FOOT].copy_length        = foot_len;
    cmds[SLOT_FOOT].mode_out           = req.transfer_mode;

    cmds[SLOT_MID].engine_source       = req.source_address + ADDR_W'(head_len);
    cmds[SLOT_MID].engine_destination  = req.destination_address + ADDR_W'(head_len);
    cmds[SLOT_MID].engine_length       = ELEN_W'(mid_len);
    cmds[SLOT_MID].via_scratch         = 1'b0;
    cmds[SLOT_MID].mode_out            = req.transfer_mode;

    cmds[SLOT_HEAD].engine_source      = src_line;
    cmds[SLOT_HEAD].engine_destination = scratch_addr;
    cmds[SLOT_HEAD].engine_length      = same_off ? head_eng : span;
    cmds[SLOT_HEAD].via_scratch        = 1'b1;
    cmds[SLOT_HEAD].copy_destination   = req.destination_address;
    cmds[SLOT_HEAD].copy_offset        = COFF_W'(soff);
    cmds[SLOT_HEAD].copy_length        = same_off ? head_fin : req.byte_count;
    cmds[SLOT_HEAD].mode_out           = req.transfer_mode;
  end

  always_comb begin
    cmd_vld            = '0;
    cmd_vld[SLOT_FOOT] = nz && same_off && !merge && (foot_len != '0);
    cmd_vld[SLOT_MID]  = nz && same_off && (mid_len != '0);
    cmd_vld[SLOT_HEAD] = nz && (!same_off || (head_fin != '0));
  end

endmodule

FILE: sv/unaligned_dma_transfer_splitter.sv
// the first command of a request passes the request register, then the output register,
//   before it is valid; an output held (valid without ready) delays it further
// throughput: one command per cycle while out_cmd.ready is high; a request produces
//   at most three commands, all issued through the single output register slot
// zero-length requests are held in the request register and dropped with no command
// reset: synchronous active-low rst_n clears valids and the scratch address
module unaligned_dma_transfer_splitter #(
  parameter int LINE_BYTES = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  uds_req_if.sink                           in_req,
  uds_cmd_if.source                         out_cmd,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [uds_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [uds_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [uds_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import uds_pkg::*;

  logic [ADDR_W-1:0]          scratch_r;
  req_t                       req_r;
  logic                       req_vld_r;
  logic [NUM_SLOTS-1:0]       done_r;
  logic                       out_vld_r;
  cmd_t                       out_r;

  cmd_t [NUM_SLOTS-1:0]       plan_cmds;
  logic [NUM_SLOTS-1:0]       plan_vld;
  logic [NUM_SLOTS-1:0]       pending;
  logic [NUM_SLOTS-1:0]       pick_oh;
  cmd_t                       pick_cmd;
  logic                       pick_last;
  logic                       load;
  logic                       retire;
  logic                       in_acc;
  logic                       cfg_wr;
  logic [CFG_IDX_W-1:0]       cfg_idx;

  // apb register
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_BYTE_W];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (psel && (cfg_idx == REG_SCRATCH)) ? CFG_DATA_W'(scratch_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scratch_r <= '0;
    end else if (cfg_wr && (cfg_idx == REG_SCRATCH)) begin
      scratch_r <= pwdata[ADDR_W-1:0];
    end
  end

  uds_plan #(
    .LINE_BYTES (LINE_BYTES)
  ) u_plan (
    .req          (req_r),
    .scratch_addr (scratch_r),
    .cmds         (plan_cmds),
    .cmd_vld      (plan_vld)
  );

  // lowest pending slot goes next: foot, middle, head
  assign pending   = plan_vld & ~done_r;
  assign pick_oh   = pending & (~pending + NUM_SLOTS'(1));
  assign pick_last = ((pending & ~pick_oh) == '0);

  always_comb begin
    pick_cmd = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick_oh[i]) begin
        pick_cmd = pick_cmd | plan_cmds[i];
      end
    end
    pick_cmd.last_command = pick_last;
  end

  assign load   = req_vld_r && (pending != '0) && (!out_vld_r || out_cmd.ready);
  assign retire = req_vld_r && ((pending == '0) || (load && pick_last));

  assign in_req.ready = !req_vld_r || retire;
  assign in_acc       = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      done_r    <= '0;
    end else begin
      if (in_acc) begin
        req_vld_r <= 1'b1;
      end else if (retire) begin
        req_vld_r <= 1'b0;
      end
      if (in_acc || retire) begin
        done_r <= '0;
      end else if (load) begin
        done_r <= done_r | pick_oh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.source_address      <= in_req.source_address;
      req_r.destination_address <= in_req.destination_address;
      req_r.byte_count          <= in_req.byte_count;
      req_r.transfer_mode       <= in_req.transfer_mode;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_cmd.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= pick_cmd;
    end
  end

  assign out_cmd.valid              = out_vld_r;
  assign out_cmd.engine_source      = out_r.engine_source;
  assign out_cmd.engine_destination = out_r.engine_destination;
  assign out_cmd.engine_length      = out_r.engine_length;
  assign out_cmd.via_scratch        = out_r.via_scratch;
  assign out_cmd.copy_destination   = out_r.copy_destination;
  assign out_cmd.copy_offset        = out_r.copy_offset;
  assign out_cmd.copy_length        = out_r.copy_length;
  assign out_cmd.mode_out           = out_r.mode_out;
  assign out_cmd.last_command       = out_r.last_command;

`ifndef SYNTHESIS
  // a freshly taken request starts with nothing emitted
  a_fresh_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (req_vld_r && (done_r == '0)))
    else $error("request register not clean after accept");

  // the last slot retires the request, so done never fills up
  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r |-> ($countones(done_r) < NUM_SLOTS))
    else $error("all command slots marked done on a live request");

  // direct commands carry no processor copy
  a_direct_nocopy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.via_scratch) |->
      ((out_r.copy_length == '0) && (out_r.copy_offset == '0)))
    else $error("direct command with processor copy");
`endif

endmodule
